@@ sv/tsavg_pkg.sv @@
package tsavg_pkg;

  // Sample and block accumulation
  localparam int SAMPLE_W = 12;
  localparam int BLOCK_LEN = 64;
  localparam int SUM_W = 24;
  localparam int FILL_W = $clog2(BLOCK_LEN) + 1;

  // Period accumulation
  localparam int PSUM_W = 32;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Result fields
  localparam int KIND_W = 2;
  localparam int AVG_W = 12;
  localparam int MV_W = 16;
  localparam int REF_W = 16;
  localparam int PROD_W = REF_W + AVG_W;
  localparam int FULL_SCALE_SH = 12;

  // Restoring divider for the period mean: one quotient bit per cycle
  localparam int DIV_STEPS = PSUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_REFERENCE_MV = 1'b0;
  localparam logic [REF_W-1:0] REFERENCE_MV_RESET = 16'd3300;

  // Request command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_BLOCK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PERIOD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic take_sample;
    logic take_tick;
    logic div_step;
    logic mul_load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic block_last;
    logic period_empty;
  } status_t;

endpackage

@@ sv/two_stage_adc_averager.sv @@
// A sample that does not close a block is taken while the controller stays idle.
// A block-closing sample takes the mean as a shift of the block sum, then the load.
// A period tick runs a 32-step restoring divider, a 16x12 multiply and the load; one with no
// blocks skips both. Requests stall until the result is loaded; one is in work at a time.
// Reset (rst, synchronous, active high) clears the block and period sums and counts, the
// saturation flag and result valid, and sets reference_mv to 3300.
module two_stage_adc_averager (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tsavg_pkg::PADDR_W-1:0]        paddr,
  input  logic [tsavg_pkg::PDATA_W-1:0]        pwdata,
  output logic [tsavg_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready,
  // Request channel
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 command,
  input  logic [tsavg_pkg::SAMPLE_W-1:0]       sample,
  // Result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [tsavg_pkg::KIND_W-1:0]         kind,
  output logic [tsavg_pkg::AVG_W-1:0]          average,
  output logic [tsavg_pkg::MV_W-1:0]           millivolts,
  output logic [tsavg_pkg::COUNT_W-1:0]        blocks_counted,
  output logic                                 saturated
);

  logic [tsavg_pkg::REF_W-1:0]     reference_mv;
  logic [tsavg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            reg_write;
  tsavg_pkg::cmd_t                 cmd;
  tsavg_pkg::status_t              status;

  assign pready = 1'b1;
  assign reg_idx = paddr[tsavg_pkg::PADDR_W-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  // Write the reference register, ignore other addresses
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mv <= tsavg_pkg::REFERENCE_MV_RESET;
    end else if (reg_write && reg_idx == tsavg_pkg::REG_REFERENCE_MV) begin
      reference_mv <= pwdata[tsavg_pkg::REF_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_idx == tsavg_pkg::REG_REFERENCE_MV) begin
      prdata = tsavg_pkg::PDATA_W'(reference_mv);
    end
  end

  tsavg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tsavg_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .sample         (sample),
    .reference_mv   (reference_mv),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .average        (average),
    .millivolts     (millivolts),
    .blocks_counted (blocks_counted),
    .saturated      (saturated)
  );

endmodule

@@ sv/tsavg_ctrl.sv @@
module tsavg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                command,
  output logic                result_valid,
  input  logic                result_stall,
  input  tsavg_pkg::status_t  status,
  output tsavg_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [tsavg_pkg::DIV_CNT_W-1:0] div_count;
  logic accept;
  logic slot_free;
  logic div_last;

  assign item_stall = (state != S_IDLE);
  assign accept = item_valid && !item_stall;
  assign slot_free = !result_valid || !result_stall;
  assign div_last = (div_count == tsavg_pkg::DIV_CNT_W'(tsavg_pkg::DIV_STEPS - 1));

  // Decode commands for the datapath
  always_comb begin
    cmd = '0;
    cmd.take_sample = accept && (command == tsavg_pkg::CMD_SAMPLE);
    cmd.take_tick = accept && (command == tsavg_pkg::CMD_TICK);
    cmd.div_step = (state == S_DIV);
    cmd.mul_load = (state == S_MUL);
    cmd.load_out = (state == S_EMIT) && slot_free;
  end

  // Sequence one request: divide, scale, emit, or emit at once
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.take_sample && status.block_last) begin
          state_next = S_EMIT;
        end else if (cmd.take_tick) begin
          state_next = status.period_empty ? S_EMIT : S_DIV;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_next = S_MUL;
        end
      end
      S_MUL: state_next = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_count <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Count divider steps, restart on every request
      if (state == S_DIV) begin
        div_count <= div_last ? '0 : div_count + 1'b1;
      end else begin
        div_count <= '0;
      end
      // Hold the result until taken, reload when the slot frees
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(result_valid && result_stall))
    else $error("result overwritten while stalled");

  a_div_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_last) |=> (state != S_DIV))
    else $error("divider ran past its step count");

  a_block_emits: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_sample && status.block_last) |=> (state == S_EMIT))
    else $error("closed block did not go straight to emit");

  a_empty_tick: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_tick && status.period_empty) |=> (state == S_EMIT))
    else $error("empty period did not go straight to emit");

endmodule

@@ sv/tsavg_dp.sv @@
module tsavg_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [tsavg_pkg::SAMPLE_W-1:0]         sample,
  input  logic [tsavg_pkg::REF_W-1:0]            reference_mv,
  input  tsavg_pkg::cmd_t                        cmd,
  output tsavg_pkg::status_t                     status,
  output logic [tsavg_pkg::KIND_W-1:0]           kind,
  output logic [tsavg_pkg::AVG_W-1:0]            average,
  output logic [tsavg_pkg::MV_W-1:0]             millivolts,
  output logic [tsavg_pkg::COUNT_W-1:0]          blocks_counted,
  output logic                                   saturated
);

  // Accumulation state
  logic [tsavg_pkg::SUM_W-1:0]   block_sum;
  logic [tsavg_pkg::FILL_W-1:0]  block_fill;
  logic [tsavg_pkg::PSUM_W-1:0]  period_sum;
  logic [tsavg_pkg::COUNT_W-1:0] period_blocks;
  logic                          period_saturated;

  // Divider, scaling and pending result
  logic [tsavg_pkg::PSUM_W-1:0]  div_quo;
  logic [tsavg_pkg::COUNT_W-1:0] div_rem;
  logic [tsavg_pkg::COUNT_W-1:0] div_den;
  logic [tsavg_pkg::PROD_W-1:0]  product;
  logic [tsavg_pkg::KIND_W-1:0]  res_kind;
  logic [tsavg_pkg::COUNT_W-1:0] rep_count;
  logic                          rep_sat;

  logic [tsavg_pkg::SUM_W-1:0]   sum_next;
  logic [tsavg_pkg::COUNT_W:0]   trial;
  logic                          fits;
  logic [tsavg_pkg::AVG_W-1:0]   quo_low;

  assign status.block_last =
    (block_fill == tsavg_pkg::FILL_W'(tsavg_pkg::BLOCK_LEN - 1));
  assign status.period_empty = (period_blocks == '0);

  assign sum_next = block_sum + tsavg_pkg::SUM_W'(sample);
  assign trial = {div_rem, div_quo[tsavg_pkg::PSUM_W-1]};
  assign fits = (trial >= {1'b0, div_den});
  assign quo_low = div_quo[tsavg_pkg::AVG_W-1:0];

  // Accumulate samples and block means into the period; a tick clears it
  always_ff @(posedge clk) begin
    if (rst) begin
      block_sum <= '0;
      block_fill <= '0;
      period_sum <= '0;
      period_blocks <= '0;
      period_saturated <= 1'b0;
    end else begin
      if (cmd.take_sample) begin
        if (status.block_last) begin
          block_sum <= '0;
          block_fill <= '0;
        end else begin
          block_sum <= sum_next;
          block_fill <= block_fill + 1'b1;
        end
      end
      if (cmd.take_tick) begin
        period_sum <= '0;
        period_blocks <= '0;
        period_saturated <= 1'b0;
      end
      // Fold the block mean in as it leaves, drop it once the count is full
      if (cmd.load_out && res_kind == tsavg_pkg::KIND_BLOCK) begin
        if (period_blocks != tsavg_pkg::COUNT_MAX) begin
          period_sum <= period_sum + tsavg_pkg::PSUM_W'(quo_low);
          period_blocks <= period_blocks + 1'b1;
        end else begin
          period_saturated <= 1'b1;
        end
      end
    end
  end

  // Take the block mean by shift, or load and step the divider, then scale
  always_ff @(posedge clk) begin
    if (cmd.take_sample && status.block_last) begin
      // BLOCK_LEN is a power of two, so this is a plain shift
      div_quo <= tsavg_pkg::PSUM_W'(sum_next / tsavg_pkg::BLOCK_LEN);
      res_kind <= tsavg_pkg::KIND_BLOCK;
    end else if (cmd.take_tick) begin
      div_quo <= period_sum;
      div_den <= period_blocks;
      div_rem <= '0;
      rep_count <= period_blocks;
      rep_sat <= period_saturated;
      res_kind <= status.period_empty ? tsavg_pkg::KIND_EMPTY : tsavg_pkg::KIND_PERIOD;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[tsavg_pkg::PSUM_W-2:0], fits};
      div_rem <= fits ? tsavg_pkg::COUNT_W'(trial - {1'b0, div_den})
                      : tsavg_pkg::COUNT_W'(trial);
    end
    if (cmd.mul_load) begin
      product <= tsavg_pkg::PROD_W'(reference_mv) * tsavg_pkg::PROD_W'(quo_low);
    end
  end

  // Present the finished result
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kind <= res_kind;
      case (res_kind)
        tsavg_pkg::KIND_BLOCK: begin
          average <= quo_low;
          millivolts <= '0;
          blocks_counted <= '0;
          saturated <= 1'b0;
        end
        tsavg_pkg::KIND_PERIOD: begin
          average <= quo_low;
          millivolts <= product[tsavg_pkg::PROD_W-1:tsavg_pkg::FULL_SCALE_SH];
          blocks_counted <= rep_count;
          saturated <= rep_sat;
        end
        default: begin
          average <= '0;
          millivolts <= '0;
          blocks_counted <= '0;
          saturated <= rep_sat;
        end
      endcase
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;

  localparam logic [tsavg_pkg::PADDR_W-1:0] ADDR_REFERENCE_MV =
    {tsavg_pkg::REG_REFERENCE_MV, 2'b00};
  // Index 1 holds no register, so writes there must be dropped
  localparam logic [tsavg_pkg::PADDR_W-1:0] ADDR_SPARE = tsavg_pkg::PADDR_W'(4);
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef enum int {FILL_MAX, FILL_ZERO, FILL_RANDOM, FILL_NEAR, FILL_RAIL} fill_mode_t;

  typedef struct packed {
    logic [tsavg_pkg::KIND_W-1:0]  kind;
    logic [tsavg_pkg::AVG_W-1:0]   average;
    logic [tsavg_pkg::MV_W-1:0]    millivolts;
    logic [tsavg_pkg::COUNT_W-1:0] blocks_counted;
    logic                          saturated;
  } report_t;

  // Block and period averaging with the queue of reports still to come
  class mean_tracker_t;
    logic [tsavg_pkg::REF_W-1:0]   ref_mv;
    logic [tsavg_pkg::SUM_W-1:0]   blk_sum;
    int unsigned                   blk_fill;
    logic [tsavg_pkg::PSUM_W-1:0]  per_sum;
    logic [tsavg_pkg::COUNT_W-1:0] per_blocks;
    logic                          per_sat;
    report_t                       expected_reports[$];
    int                            failures;

    function new();
      ref_mv = tsavg_pkg::REFERENCE_MV_RESET;
      blk_sum = '0;
      blk_fill = 0;
      per_sum = '0;
      per_blocks = '0;
      per_sat = 1'b0;
      failures = 0;
    endfunction

    function void set_reference(logic [tsavg_pkg::REF_W-1:0] value);
      ref_mv = value;
    endfunction

    function int unsigned fill_level();
      return blk_fill;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void take_request(logic cmd, logic [tsavg_pkg::SAMPLE_W-1:0] smp);
      report_t r;
      logic [tsavg_pkg::AVG_W-1:0] mean;
      logic [tsavg_pkg::PROD_W-1:0] prod;
      r = '0;
      if (cmd == tsavg_pkg::CMD_SAMPLE) begin
        blk_sum = blk_sum + smp;
        blk_fill++;
        if (blk_fill < tsavg_pkg::BLOCK_LEN) return;
        mean = tsavg_pkg::AVG_W'(blk_sum / tsavg_pkg::BLOCK_LEN);
        blk_sum = '0;
        blk_fill = 0;
        // Count full: still report the block but drop it from the period
        if (per_blocks < tsavg_pkg::COUNT_MAX) begin
          per_sum = per_sum + mean;
          per_blocks = per_blocks + 1'b1;
        end else begin
          per_sat = 1'b1;
        end
        r.kind = tsavg_pkg::KIND_BLOCK;
        r.average = mean;
      end else begin
        if (per_blocks != 0) begin
          mean = tsavg_pkg::AVG_W'(per_sum / per_blocks);
          prod = ref_mv * mean;
          r.kind = tsavg_pkg::KIND_PERIOD;
          r.average = mean;
          r.millivolts = tsavg_pkg::MV_W'(prod >> tsavg_pkg::FULL_SCALE_SH);
          r.blocks_counted = per_blocks;
        end else begin
          r.kind = tsavg_pkg::KIND_EMPTY;
        end
        r.saturated = per_sat;
        per_sum = '0;
        per_blocks = '0;
        per_sat = 1'b0;
      end
      expected_reports.push_back(r);
    endfunction

    function void check_report(report_t got);
      report_t exp;
      if (expected_reports.size() == 0) begin
        $error("report with none expected: kind %0d average %0d", got.kind, got.average);
        failures++;
        return;
      end
      exp = expected_reports.pop_front();
      if (got.kind !== exp.kind) begin
        $error("kind: expected %0d, got %0d", exp.kind, got.kind);
        failures++;
      end
      if (got.average !== exp.average) begin
        $error("average: expected %0d, got %0d", exp.average, got.average);
        failures++;
      end
      if (got.millivolts !== exp.millivolts) begin
        $error("millivolts: expected %0d, got %0d", exp.millivolts, got.millivolts);
        failures++;
      end
      if (got.blocks_counted !== exp.blocks_counted) begin
        $error("blocks_counted: expected %0d, got %0d", exp.blocks_counted,
               got.blocks_counted);
        failures++;
      end
      if (got.saturated !== exp.saturated) begin
        $error("saturated: expected %0d, got %0d", exp.saturated, got.saturated);
        failures++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [tsavg_pkg::PADDR_W-1:0]   paddr = '0;
  logic [tsavg_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [tsavg_pkg::PDATA_W-1:0]   prdata;
  logic                            pready;
  logic                            item_valid = 1'b0;
  logic                            item_stall;
  logic                            command = tsavg_pkg::CMD_SAMPLE;
  logic [tsavg_pkg::SAMPLE_W-1:0]  sample = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic [tsavg_pkg::KIND_W-1:0]    kind;
  logic [tsavg_pkg::AVG_W-1:0]     average;
  logic [tsavg_pkg::MV_W-1:0]      millivolts;
  logic [tsavg_pkg::COUNT_W-1:0]   blocks_counted;
  logic                            saturated;

  mean_tracker_t tracker = new();
  int burst_left = 0;
  int blocks_made = 0;
  bit long_hold_due = 1'b0;

  two_stage_adc_averager DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .command(command),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .average(average),
    .millivolts(millivolts),
    .blocks_counted(blocks_counted),
    .saturated(saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // Check every report taken from the result channel
  always @(posedge clk) begin
    report_t got;
    if (!rst && result_valid && !result_stall) begin
      got = '{kind, average, millivolts, blocks_counted, saturated};
      tracker.check_report(got);
    end
  end

  // Stall the result channel: free runs, coin flips, square waves, heavy stall
  initial begin
    int mode;
    int span;
    int half;
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      half = $urandom_range(1, 5);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= $urandom_range(0, 1);
          2: result_stall <= ((i / half) % 2) != 0;
          default: result_stall <= $urandom_range(0, 3) != 0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one request, idling between bursts, and hold it until taken
  task automatic send_request(logic cmd, logic [tsavg_pkg::SAMPLE_W-1:0] smp);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    item_valid <= 1'b1;
    command <= cmd;
    sample <= smp;
    do @(posedge clk); while (item_stall);
    tracker.take_request(cmd, smp);
  endtask

  task automatic reg_write(logic [tsavg_pkg::PADDR_W-1:0] addr,
                           logic [tsavg_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr[tsavg_pkg::PADDR_W-1:2] == tsavg_pkg::REG_REFERENCE_MV) begin
      tracker.set_reference(data[tsavg_pkg::REF_W-1:0]);
    end
  endtask

  task automatic reg_read_check(logic [tsavg_pkg::PADDR_W-1:0] addr,
                                logic [tsavg_pkg::REF_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== tsavg_pkg::PDATA_W'(value)) begin
      $error("reference_mv: expected %0d, got %0d", value, prdata);
      tracker.failures++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain all reports, then give a non-closing sample time to finish
  task automatic settle();
    item_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [tsavg_pkg::SAMPLE_W-1:0] pick_sample(fill_mode_t mode, int center);
    int v;
    case (mode)
      FILL_MAX: v = 4095;
      FILL_ZERO: v = 0;
      FILL_NEAR: begin
        v = center + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      FILL_RAIL: v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = $urandom_range(0, 4095);
    endcase
    return tsavg_pkg::SAMPLE_W'(v);
  endfunction

  // Complete blocks, leave some partial, close periods with one or two ticks
  task automatic run_random(int budget);
    int sent;
    int blocks;
    int n;
    int center;
    fill_mode_t mode;
    sent = 0;
    while (sent < budget) begin
      blocks = $urandom_range(0, 3);
      for (int b = 0; b < blocks && sent < budget; b++) begin
        if (blocks_made == 1) mode = FILL_MAX;
        else if (blocks_made == 2) mode = FILL_ZERO;
        else mode = fill_mode_t'($urandom_range(0, 4));
        center = $urandom_range(0, 4095);
        n = tsavg_pkg::BLOCK_LEN - tracker.fill_level();
        repeat (n) send_request(tsavg_pkg::CMD_SAMPLE, pick_sample(mode, center));
        sent += n;
        blocks_made++;
      end
      if (sent < budget && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, tsavg_pkg::BLOCK_LEN - 1);
        repeat (n) begin
          send_request(tsavg_pkg::CMD_SAMPLE, tsavg_pkg::SAMPLE_W'($urandom_range(0, 4095)));
        end
        sent += n;
      end
      repeat ($urandom_range(1, 2)) begin
        send_request(tsavg_pkg::CMD_TICK, tsavg_pkg::SAMPLE_W'($urandom_range(0, 4095)));
        sent++;
      end
    end
  endtask

  initial begin
    logic [tsavg_pkg::REF_W-1:0] ref_value;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    reg_read_check(ADDR_REFERENCE_MV, tsavg_pkg::REFERENCE_MV_RESET);

    // Empty period, sample extremes and bit patterns, partial block across ticks
    send_request(tsavg_pkg::CMD_TICK, 12'h000);
    send_request(tsavg_pkg::CMD_SAMPLE, 12'h000);
    send_request(tsavg_pkg::CMD_SAMPLE, 12'hFFF);
    send_request(tsavg_pkg::CMD_SAMPLE, 12'hAAA);
    send_request(tsavg_pkg::CMD_SAMPLE, 12'h555);
    send_request(tsavg_pkg::CMD_TICK, 12'hFFF);
    send_request(tsavg_pkg::CMD_TICK, 12'h555);
    settle();
    reg_write(ADDR_SPARE, 32'hFFFF_1234);
    reg_read_check(ADDR_REFERENCE_MV, tsavg_pkg::REFERENCE_MV_RESET);
    run_random(120);

    // Full-scale reference, with one long stall of the result channel
    settle();
    reg_write(ADDR_REFERENCE_MV, 32'h0000_FFFF);
    reg_read_check(ADDR_REFERENCE_MV, 16'hFFFF);
    long_hold_due = 1'b1;
    run_random(120);

    // Zero reference forces zero millivolts
    settle();
    reg_write(ADDR_REFERENCE_MV, 32'h0000_0000);
    reg_read_check(ADDR_REFERENCE_MV, 16'h0000);
    run_random(80);

    settle();
    reg_write(ADDR_REFERENCE_MV, 32'h0000_0001);
    reg_read_check(ADDR_REFERENCE_MV, 16'h0001);
    run_random(80);

    // Random reference with noise in the unused upper bits
    settle();
    ref_value = tsavg_pkg::REF_W'($urandom_range(1, 65535));
    reg_write(ADDR_REFERENCE_MV, {16'($urandom), ref_value});
    reg_read_check(ADDR_REFERENCE_MV, ref_value);
    run_random(120);

    settle();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/tsavg_pkg.sv
sv/tsavg_ctrl.sv
sv/tsavg_dp.sv
sv/two_stage_adc_averager.sv
sim/tb.sv
